// ===== src/asx_pkg.sv =====
// Shared types, constants and helpers for the AML sleep type extractor.
// Used by asx_parser and aml_sleep_type_extractor; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package asx_pkg;

   localparam int HEADER_BYTES_DEF = 36;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_TYPE_A = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_TYPE_B = 1'b1;
   localparam logic [7:0] DEFAULT_TYPE_RESET = 8'd5;

   // AML constants
   localparam logic [7:0]  PKG_OP    = 8'h12;
   localparam logic [7:0]  BYTE_PFX  = 8'h0A;
   localparam logic [31:0] NAME_S5   = 32'h5F53_355F;  // "_S5_"
   localparam logic [31:0] SIG_DSDT  = 32'h5444_5344;  // "DSDT", first char low
   localparam logic [15:0] SLP_EN    = 16'h2000;
   localparam int          TYP_SHIFT = 10;
   localparam int          LEN_SHIFT = 6;

   typedef enum logic [8:0] {
      PH_HEADER = 9'b0_0000_0001,
      PH_SCAN   = 9'b0_0000_0010,
      PH_LEAD   = 9'b0_0000_0100,
      PH_SKIP   = 9'b0_0000_1000,
      PH_ELEM_A = 9'b0_0001_0000,
      PH_DATA_A = 9'b0_0010_0000,
      PH_ELEM_B = 9'b0_0100_0000,
      PH_DATA_B = 9'b0_1000_0000,
      PH_IDLE   = 9'b1_0000_0000
   } phase_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  type_a;
      logic [7:0]  type_b;
      logic [15:0] word_a;
      logic [15:0] word_b;
   } result_type;

   // Power control word: enable bit plus type in bits 15:10, upper type bits drop.
   function automatic logic [15:0] control_word(input logic [7:0] slp_type);
      logic [15:0] shifted;
      shifted = {slp_type[15-TYP_SHIFT:0], {TYP_SHIFT{1'b0}}};
      return SLP_EN | shifted;
   endfunction

endpackage

`default_nettype wire

// ===== src/aml_sleep_type_extractor.sv =====
// Top level of the AML sleep type extractor: stream ports, config registers,
// input and result registers. Depends on asx_pkg and asx_parser.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   req_*: one table byte per transfer, header first, then the AML body;
//          req_tlast marks the final byte of a table.
//   rsp_*: exactly one transfer per table. rsp_tuser is the found flag;
//          rsp_tdata carries both sleep types and both power control words.
//          A found result leaves on the byte completing the second package
//          element; otherwise the defaults leave on the last byte.
//   csr_*: write the default sleep types (index 0 = A, 1 = B) while idle.
// Timing
//   A byte lands in the input register at its transfer edge and is parsed
//   once the result register can take a result; any result is written to
//   the result register at the edge that ends its parse, raising rsp_tvalid.
//   One byte per cycle is sustained while no response is stalled; the parse
//   is a single next-state update per byte.
// Reset
//   Clears both registers' valid bits, the parse state and sets both
//   default types to 5.
// Backpressure
//   While rsp_tvalid is high and rsp_tready is low, the parser holds and the
//   input register stays full, so req_tready drops after at most one more byte.

module aml_sleep_type_extractor #(
   parameter int HEADER_BYTES = asx_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request stream
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] table_byte
   input  wire logic                          req_tlast,   // last_byte
   // response stream
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] sleep_type_a, [15:8] sleep_type_b,
   // [31:16] control_word_a, [47:32] control_word_b
   output logic [47:0]                        rsp_tdata,
   output logic                               rsp_tuser,   // [0] found
   // configuration writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [asx_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                    csr_data
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   asx_pkg::result_type rsp_ff;

   // configuration
   logic [7:0] def_a_ff;
   logic [7:0] def_b_ff;

   logic                step_en;
   logic                res_valid;
   asx_pkg::result_type res;

   // parse the held byte when the result register can take a result
   assign step_en     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step_en;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload: load on every transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   asx_parser #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .table_byte     (in_byte_ff),
      .last_byte      (in_last_ff),
      .default_type_a (def_a_ff),
      .default_type_b (def_b_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   // hold a result until taken; a new one only arrives when the slot frees
   assign rsp_valid_in = res_valid ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.found;
   assign rsp_tdata  = {rsp_ff.word_b, rsp_ff.word_a, rsp_ff.type_b, rsp_ff.type_a};

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         def_a_ff <= asx_pkg::DEFAULT_TYPE_RESET;
         def_b_ff <= asx_pkg::DEFAULT_TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            asx_pkg::REG_DEFAULT_TYPE_A: def_a_ff <= csr_data;
            asx_pkg::REG_DEFAULT_TYPE_B: def_b_ff <= csr_data;
            default: begin
               def_a_ff <= def_a_ff;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/asx_parser.sv =====
// Per-byte table parser: signature check, "_S5_" scan and package decode.
// Depends on asx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asx_parser #(
   parameter int HEADER_BYTES = asx_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire logic [7:0]           table_byte,
   input  wire logic                 last_byte,
   input  wire logic [7:0]           default_type_a,
   input  wire logic [7:0]           default_type_b,
   output logic                      res_valid,
   output asx_pkg::result_type       res
);

   localparam int POS_W = $clog2(HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);

   asx_pkg::phase_type phase_ff, phase_in;
   logic [31:0]      recent_ff, recent_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       skip_ff, skip_in;
   logic             sig_good_ff, sig_good_in;
   logic [7:0]       first_type_ff, first_type_in;
   logic             sent_ff, sent_in;

   logic             done;
   logic [7:0]       type_b;
   logic [7:0]       sig_byte;
   logic             pos_in_sig;

   assign sig_byte   = asx_pkg::SIG_DSDT[8*pos_ff[1:0] +: 8];
   assign pos_in_sig = ({{(32-POS_W){1'b0}}, pos_ff} < 32'd4);

   always_comb begin
      phase_in      = phase_ff;
      recent_in     = recent_ff;
      pos_in        = pos_ff;
      skip_in       = skip_ff;
      sig_good_in   = sig_good_ff;
      first_type_in = first_type_ff;
      sent_in       = sent_ff;
      done          = 1'b0;
      type_b        = 8'd0;
      res_valid     = 1'b0;
      res           = '0;

      case (phase_ff)
         asx_pkg::PH_HEADER: begin
            if (pos_in_sig && table_byte != sig_byte) begin
               sig_good_in = 1'b0;
            end
            if (pos_ff == POS_LAST) begin
               phase_in = sig_good_in ? asx_pkg::PH_SCAN : asx_pkg::PH_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         asx_pkg::PH_SCAN: begin
            if (table_byte == asx_pkg::PKG_OP && recent_ff == asx_pkg::NAME_S5) begin
               phase_in = asx_pkg::PH_LEAD;
            end else begin
               recent_in = {recent_ff[23:0], table_byte};
            end
         end
         asx_pkg::PH_LEAD: begin
            // package length: lead byte plus up to three more
            skip_in  = {1'b0, table_byte[7:asx_pkg::LEN_SHIFT]} + 3'd1;
            phase_in = asx_pkg::PH_SKIP;
         end
         asx_pkg::PH_SKIP: begin
            if (skip_ff <= 3'd1) begin
               skip_in  = 3'd0;
               phase_in = asx_pkg::PH_ELEM_A;
            end else begin
               skip_in = skip_ff - 3'd1;
            end
         end
         asx_pkg::PH_ELEM_A: begin
            if (table_byte == asx_pkg::BYTE_PFX) begin
               phase_in = asx_pkg::PH_DATA_A;
            end else begin
               first_type_in = table_byte;
               phase_in      = asx_pkg::PH_ELEM_B;
            end
         end
         asx_pkg::PH_DATA_A: begin
            first_type_in = table_byte;
            phase_in      = asx_pkg::PH_ELEM_B;
         end
         asx_pkg::PH_ELEM_B: begin
            if (table_byte == asx_pkg::BYTE_PFX) begin
               phase_in = asx_pkg::PH_DATA_B;
            end else begin
               type_b = table_byte;
               done   = 1'b1;
            end
         end
         asx_pkg::PH_DATA_B: begin
            type_b = table_byte;
            done   = 1'b1;
         end
         default: begin
            phase_in = asx_pkg::PH_IDLE;
         end
      endcase

      if (done) begin
         res_valid   = 1'b1;
         res.found   = 1'b1;
         res.type_a  = first_type_ff;
         res.type_b  = type_b;
         sent_in     = 1'b1;
         phase_in    = asx_pkg::PH_IDLE;
      end

      if (last_byte) begin
         if (!sent_ff && !done) begin
            res_valid  = 1'b1;
            res.found  = 1'b0;
            res.type_a = default_type_a;
            res.type_b = default_type_b;
         end
         // table ends: start over for the next one
         phase_in      = asx_pkg::PH_HEADER;
         recent_in     = 32'd0;
         pos_in        = '0;
         skip_in       = 3'd0;
         sig_good_in   = 1'b1;
         first_type_in = 8'd0;
         sent_in       = 1'b0;
      end

      res.word_a = asx_pkg::control_word(res.type_a);
      res.word_b = asx_pkg::control_word(res.type_b);
      res_valid  = res_valid && step_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= asx_pkg::PH_HEADER;
         recent_ff     <= 32'd0;
         pos_ff        <= '0;
         skip_ff       <= 3'd0;
         sig_good_ff   <= 1'b1;
         first_type_ff <= 8'd0;
         sent_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         recent_ff     <= recent_in;
         pos_ff        <= pos_in;
         skip_ff       <= skip_in;
         sig_good_ff   <= sig_good_in;
         first_type_ff <= first_type_in;
         sent_ff       <= sent_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/asx_checker.sv =====
// Port-level checks for aml_sleep_type_extractor, bound to the top level.
// Depends on nothing but the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

module asx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // control words follow the sleep types
   a_word_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] == (16'h2000 | {rsp_tdata[5:0], 10'b0}))
      else $error("control word A does not match sleep type A");

   a_word_b: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:32] == (16'h2000 | {rsp_tdata[13:8], 10'b0}))
      else $error("control word B does not match sleep type B");

   // no response right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind aml_sleep_type_extractor asx_checker u_asx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
